/* rtl/csev_pkg.sv */
// shared constants, request codes and pipeline control record for the spline evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package csev_pkg;

	localparam int DEF_POINT_WIDTH     = 32;
	localparam int DEF_PARAM_FRAC_BITS = 16;

	// horner steps, one cell each
	localparam int NUM_CELLS = 3;

	// request accepted to done strobe, in clock edges
	localparam int LATENCY = 2 * NUM_CELLS + 2;

	typedef enum logic [1:0] {
		REQ_VALUE = 2'd0,
		REQ_SLOPE = 2'd1,
		REQ_CURV  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	// travels with each request down the chain
	typedef struct packed {
		logic                 valid;
		logic                 blank;
		logic [NUM_CELLS-1:0] use_t;
	} ctl_t;

endpackage

`default_nettype wire

/* rtl/csev_front.sv */
// input stage: clamps t, forms the doubled coefficients and the scaled horner addends
// depends on csev_pkg
`default_nettype none

module csev_front #(
	parameter int POINT_WIDTH     = csev_pkg::DEF_POINT_WIDTH,
	parameter int PARAM_FRAC_BITS = csev_pkg::DEF_PARAM_FRAC_BITS,
	localparam int ACC_W          = POINT_WIDTH + 3 * PARAM_FRAC_BITS + 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        take,
	input  logic [1:0]                                  req_type,
	input  logic [PARAM_FRAC_BITS:0]                    param_t,
	input  logic signed [POINT_WIDTH-1:0]               point_before,
	input  logic signed [POINT_WIDTH-1:0]               point_start,
	input  logic signed [POINT_WIDTH-1:0]               point_end,
	input  logic signed [POINT_WIDTH-1:0]               point_after,
	output csev_pkg::ctl_t                              ctl_o,
	output logic [PARAM_FRAC_BITS:0]                    t_o,
	output logic [ACC_W-1:0]                            acc_o,
	output logic [csev_pkg::NUM_CELLS-1:0][ACC_W-1:0]   add_o
);
	import csev_pkg::*;

	localparam int F = PARAM_FRAC_BITS;

	logic [F:0]                        t_clamp;
	logic signed [ACC_W-1:0]           x0, x1, x2, x3;
	logic signed [ACC_W-1:0]           d12, a2, b2, c2;
	logic [ACC_W-1:0]                  acc_d;
	logic [NUM_CELLS-1:0][ACC_W-1:0]   add_d;
	ctl_t                              ctl_d;

	// t above one is held at one
	assign t_clamp = (param_t[F] && (|param_t[F-1:0])) ? {1'b1, {F{1'b0}}} : param_t;

	assign x0 = ACC_W'(point_before);
	assign x1 = ACC_W'(point_start);
	assign x2 = ACC_W'(point_end);
	assign x3 = ACC_W'(point_after);

	// doubled coefficients
	assign d12 = x1 - x2;
	assign a2  = (d12 <<< 1) + d12 + x3 - x0;
	assign b2  = (x2 <<< 2) + (x0 <<< 1) - x3 - ((x1 <<< 2) + x1);
	assign c2  = x2 - x0;

	// derivatives are scaled up by powers of t's unit so all modes share one rounding point
	always_comb begin
		acc_d       = '0;
		add_d       = '0;
		ctl_d.valid = take;
		ctl_d.blank = 1'b0;
		ctl_d.use_t = '0;
		unique case (req_type_t'(req_type))
			REQ_VALUE: begin
				acc_d       = a2;
				add_d[0]    = b2 <<< F;
				add_d[1]    = c2 <<< (2 * F);
				add_d[2]    = x1 <<< (3 * F + 1);
				ctl_d.use_t = 3'b111;
			end
			REQ_SLOPE: begin
				acc_d       = (a2 <<< 1) + a2;
				add_d[0]    = b2 <<< (F + 1);
				add_d[1]    = c2 <<< (2 * F);
				ctl_d.use_t = 3'b011;
			end
			REQ_CURV: begin
				acc_d       = (a2 <<< 2) + (a2 <<< 1);
				add_d[0]    = b2 <<< (F + 1);
				ctl_d.use_t = 3'b001;
			end
			default: begin
				ctl_d.blank = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		t_o   <= t_clamp;
		acc_o <= acc_d;
		add_o <= add_d;
	end

endmodule

`default_nettype wire

/* rtl/csev_cell.sv */
// one horner cell: acc * m + addend, with m either t or one, over two stages
// depends on csev_pkg
`default_nettype none

module csev_cell #(
	parameter int POINT_WIDTH     = csev_pkg::DEF_POINT_WIDTH,
	parameter int PARAM_FRAC_BITS = csev_pkg::DEF_PARAM_FRAC_BITS,
	localparam int ACC_W          = POINT_WIDTH + 3 * PARAM_FRAC_BITS + 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  csev_pkg::ctl_t                              ctl_i,
	input  logic [PARAM_FRAC_BITS:0]                    t_i,
	input  logic [ACC_W-1:0]                            acc_i,
	input  logic [csev_pkg::NUM_CELLS-1:0][ACC_W-1:0]   add_i,
	output csev_pkg::ctl_t                              ctl_o,
	output logic [PARAM_FRAC_BITS:0]                    t_o,
	output logic [ACC_W-1:0]                            acc_o,
	output logic [csev_pkg::NUM_CELLS-1:0][ACC_W-1:0]   add_o
);
	import csev_pkg::*;

	localparam int F     = PARAM_FRAC_BITS;
	localparam int HALF  = ACC_W / 2;
	localparam int HI_W  = ACC_W - HALF;
	localparam int LO_PW = HALF + F + 1;
	localparam int HI_PW = HI_W + F + 2;

	logic [F:0]                        mul_op;
	logic [LO_PW-1:0]                  lo_prod;
	logic signed [HI_PW-1:0]           hi_prod;

	logic [LO_PW-1:0]                  lo_s1;
	logic [HI_W-1:0]                   hi_s1;
	logic [NUM_CELLS-1:0][ACC_W-1:0]   add_s1;
	logic [F:0]                        t_s1;
	ctl_t                              ctl_s1;

	logic [ACC_W-1:0]                  sum;
	ctl_t                              ctl_s2;

	assign mul_op = ctl_i.use_t[0] ? t_i : {1'b1, {F{1'b0}}};

	// split product; the high part only matters modulo the accumulator width
	assign lo_prod = LO_PW'(acc_i[HALF-1:0]) * LO_PW'(mul_op);
	assign hi_prod = HI_PW'($signed(acc_i[ACC_W-1:HALF])) * HI_PW'($signed({1'b0, mul_op}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= '{valid: ctl_s1.valid, blank: ctl_s1.blank,
				use_t: ctl_s1.use_t >> 1};
		end
	end

	assign sum = {hi_s1, {HALF{1'b0}}} + ACC_W'(lo_s1) + add_s1[0];

	always_ff @(posedge clk) begin
		lo_s1  <= lo_prod;
		hi_s1  <= hi_prod[HI_W-1:0];
		add_s1 <= add_i;
		t_s1   <= t_i;
		acc_o  <= sum;
		t_o    <= t_s1;
		for (int i = 0; i < NUM_CELLS - 1; i++) begin
			add_o[i] <= add_s1[i+1];
		end
		add_o[NUM_CELLS-1] <= '0;
	end

	assign ctl_o = ctl_s2;

endmodule

`default_nettype wire

/* rtl/csev_round.sv */
// output stage: round to nearest (ties up), saturate to the point range, zero for the unused mode, register the result
// depends on csev_pkg
`default_nettype none

module csev_round #(
	parameter int POINT_WIDTH     = csev_pkg::DEF_POINT_WIDTH,
	parameter int PARAM_FRAC_BITS = csev_pkg::DEF_PARAM_FRAC_BITS,
	localparam int ACC_W          = POINT_WIDTH + 3 * PARAM_FRAC_BITS + 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csev_pkg::ctl_t                ctl_i,
	input  logic [ACC_W-1:0]              acc_i,
	output logic                          done,
	output logic signed [POINT_WIDTH-1:0] curve_result,
	output logic                          clipped
);
	import csev_pkg::*;

	localparam int W   = POINT_WIDTH;
	localparam int SH  = 3 * PARAM_FRAC_BITS + 1;
	localparam int QW  = ACC_W - SH;

	logic [ACC_W-1:0]  rsum;
	logic [QW-1:0]     quot;
	logic [QW-W:0]     top_bits;
	logic              fits;
	logic [W-1:0]      res_d;
	logic              clip_d;

	assign rsum     = acc_i + (ACC_W'(1) << (SH - 1));
	assign quot     = rsum[ACC_W-1:SH];
	assign top_bits = quot[QW-1:W-1];
	assign fits     = (&top_bits) | ~(|top_bits);

	always_comb begin
		if (ctl_i.blank) begin
			res_d  = '0;
			clip_d = 1'b0;
		end else if (fits) begin
			res_d  = quot[W-1:0];
			clip_d = 1'b0;
		end else begin
			res_d  = quot[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			clip_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		curve_result <= res_d;
		clipped      <= clip_d;
	end

endmodule

`default_nettype wire

/* rtl/cubic_spline_evaluator_unit.sv */
// top level of the catmull-rom segment evaluator: front stage, chain of horner cells, rounding
// depends on csev_pkg, csev_front, csev_cell, csev_round
// done pulses once a request has passed the registered stages (front 1, 3 cells x 2, round 1)
// throughput: one request per cycle while busy is low, set by the horner cell chain with its split multipliers
// the receiver cannot stall: every result is shown for exactly one cycle with done
// reset: asynchronous, active low; clears the valid flags of all stages, busy is set by reset
// and cleared by the first clock edge after it, then stays low
`default_nettype none

module cubic_spline_evaluator_unit #(
	parameter int POINT_WIDTH     = csev_pkg::DEF_POINT_WIDTH,
	parameter int PARAM_FRAC_BITS = csev_pkg::DEF_PARAM_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [PARAM_FRAC_BITS:0]      param_t,
	input  logic signed [POINT_WIDTH-1:0] point_before,
	input  logic signed [POINT_WIDTH-1:0] point_start,
	input  logic signed [POINT_WIDTH-1:0] point_end,
	input  logic signed [POINT_WIDTH-1:0] point_after,
	output logic                          done,
	output logic signed [POINT_WIDTH-1:0] curve_result,
	output logic                          clipped
);
	import csev_pkg::*;

	// accumulator wide enough for the exact numerator at the common rounding point
	localparam int ACC_W = POINT_WIDTH + 3 * PARAM_FRAC_BITS + 8;

	logic                                          busy_q;
	logic                                          take;

	// chain links: index 0 is the front stage output, index NUM_CELLS feeds rounding
	ctl_t [NUM_CELLS:0]                            ctl_chain;
	logic [NUM_CELLS:0][PARAM_FRAC_BITS:0]         t_chain;
	logic [NUM_CELLS:0][ACC_W-1:0]                 acc_chain;
	logic [NUM_CELLS:0][NUM_CELLS-1:0][ACC_W-1:0]  add_chain;

	// busy only guards the cycles around reset; the pipe takes a request every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign take = start & ~busy_q;

	// coefficient forming and mode-dependent addend scaling
	csev_front #(
		.POINT_WIDTH     (POINT_WIDTH),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.req_type     (req_type),
		.param_t      (param_t),
		.point_before (point_before),
		.point_start  (point_start),
		.point_end    (point_end),
		.point_after  (point_after),
		.ctl_o        (ctl_chain[0]),
		.t_o          (t_chain[0]),
		.acc_o        (acc_chain[0]),
		.add_o        (add_chain[0])
	);

	// horner chain: each cell consumes the head addend and shifts the rest along
	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		csev_cell #(
			.POINT_WIDTH     (POINT_WIDTH),
			.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_chain[g]),
			.t_i    (t_chain[g]),
			.acc_i  (acc_chain[g]),
			.add_i  (add_chain[g]),
			.ctl_o  (ctl_chain[g+1]),
			.t_o    (t_chain[g+1]),
			.acc_o  (acc_chain[g+1]),
			.add_o  (add_chain[g+1])
		);
	end

	// single rounding and saturation at the end of the chain
	csev_round #(
		.POINT_WIDTH     (POINT_WIDTH),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_i        (ctl_chain[NUM_CELLS]),
		.acc_i        (acc_chain[NUM_CELLS]),
		.done         (done),
		.curve_result (curve_result),
		.clipped      (clipped)
	);

endmodule

`default_nettype wire

/* rtl/csev_checker.sv */
// port-level checker for the spline evaluator, bound to the top level
// depends on csev_pkg and cubic_spline_evaluator_unit
`default_nettype none

module csev_checker #(
	parameter int POINT_WIDTH = csev_pkg::DEF_POINT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic                          done,
	input  logic signed [POINT_WIDTH-1:0] curve_result,
	input  logic                          clipped
);
	import csev_pkg::*;

	localparam logic [POINT_WIDTH-1:0] MAX_VAL = {1'b0, {(POINT_WIDTH-1){1'b1}}};
	localparam logic [POINT_WIDTH-1:0] MIN_VAL = {1'b1, {(POINT_WIDTH-1){1'b0}}};

	// every accepted request comes back after the fixed latency
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request not answered after fixed latency");

	// no result without a request at the matching time
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	// a clipped result sits on one of the bounds
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (curve_result == MAX_VAL || curve_result == MIN_VAL))
		else $error("clipped result not at a bound");

	// unused mode yields zero, unclipped
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(req_type, LATENCY) == REQ_NONE) |-> (curve_result == '0 && !clipped))
		else $error("unused mode gave a nonzero result");

endmodule

bind cubic_spline_evaluator_unit csev_checker #(
	.POINT_WIDTH (POINT_WIDTH)
) u_csev_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req_type     (req_type),
	.done         (done),
	.curve_result (curve_result),
	.clipped      (clipped)
);

`default_nettype wire
